### rtl/sepd_pkg.sv
// sepd_pkg: shared types, constants and helpers of the scan line edge pair detector
// used by sepd_core, sepd_fifo and scanline_edge_pair_detector; no dependencies
`default_nettype none

package sepd_pkg;

	// row range and counter limits
	localparam int unsigned MAX_ROWS_DEF = 1024;
	localparam int unsigned ROW_W        = 10;
	localparam int unsigned PROW_W       = 11;
	localparam int unsigned CNT_W        = 11;
	localparam logic [CNT_W-1:0] COUNT_CAP = 11'd2047;

	// configuration register reset value
	localparam logic [7:0] THR_RESET = 8'd8;

	// result kinds
	localparam logic KIND_PAIR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// one result item
	typedef struct packed {
		logic              kind;
		logic              at_start;
		logic [PROW_W-1:0] begin_row;
		logic [PROW_W-1:0] end_row;
		logic [5:0]        line_id;
		logic              last;
	} res_t;

	// results pushed by the core in one cycle, slot 0 first
	typedef struct packed {
		logic v0;
		logic v1;
		res_t r0;
		res_t r1;
	} push_t;

	// green share above 0.3: 10 * green_count > 3 * segment_length
	function automatic logic green_enough(input logic [CNT_W-1:0] gc,
			input logic [CNT_W-1:0] sl);
		logic [CNT_W+3:0] lhs;
		logic [CNT_W+3:0] rhs;
		lhs = {4'b0, gc} * 15'd10;
		rhs = {4'b0, sl} * 15'd3;
		return lhs > rhs;
	endfunction

endpackage

`default_nettype wire

### rtl/sepd_fifo.sv
// sepd_fifo: four-entry result queue, takes up to two results per cycle
// depends on sepd_pkg for res_t and push_t
`default_nettype none

module sepd_fifo
	import sepd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       room,
	output logic       out_valid,
	input  wire logic  out_ready,
	output res_t       out_res
);

	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W2 = $clog2(DEPTH + 1);

	res_t              mem [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W2-1:0] count_q;
	logic              pop;
	logic [CNT_W2-1:0] push_n;

	assign pop       = out_valid && out_ready;
	assign out_valid = count_q != '0;
	assign out_res   = mem[rd_ptr_q];
	// room for two results, so a full item always fits
	assign room      = count_q <= CNT_W2'(DEPTH - 2);
	assign push_n    = CNT_W2'(push.v0) + CNT_W2'(push.v1);

	// entry storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + push_n - CNT_W2'(pop);
		end
	end

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W2'(DEPTH))
		else $error("result queue overfilled");

	// a push only comes while there was room for it
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.v0 |-> room)
		else $error("result pushed without room");

endmodule

`default_nettype wire

### rtl/sepd_core.sv
// sepd_core: input register, per-line gradient state and single-pass result logic
// depends on sepd_pkg for types, constants and green_enough
`default_nettype none

module sepd_core
	import sepd_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [7:0]       cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       in_luma,
	input  wire logic             in_green,
	input  wire logic [ROW_W-1:0] in_row,
	input  wire logic             in_first,
	input  wire logic             in_last,
	input  wire logic [5:0]       in_id,
	input  wire logic             room,
	output push_t                 push
);

	localparam logic [12:0] MAX_ROWS_W = 13'(MAX_ROWS);

	// configuration
	logic [7:0] thr_q;

	// input register
	logic             valid_s1;
	logic [7:0]       luma_s1;
	logic             green_s1;
	logic [ROW_W-1:0] row_s1;
	logic             first_s1;
	logic             last_s1;
	logic [5:0]       id_s1;

	// line state
	logic [7:0]         prev_luma_q;
	logic signed [10:0] grad_max_q;
	logic signed [10:0] grad_min_q;
	logic [PROW_W-1:0]  peak_row_q;
	logic               begin_seen_q;
	logic [PROW_W-1:0]  pend_row_q;
	logic [CNT_W-1:0]   green_cnt_q;
	logic [CNT_W-1:0]   seg_len_q;
	logic [PROW_W-1:0]  green_end_q;
	logic [ROW_W-1:0]   start_row_q;

	// next state
	logic               proc;
	logic signed [10:0] gmax_d;
	logic signed [10:0] gmin_d;
	logic [PROW_W-1:0]  peak_d;
	logic               bs_d;
	logic [PROW_W-1:0]  pend_d;
	logic [CNT_W-1:0]   gc_d;
	logic [CNT_W-1:0]   sl_d;
	logic [PROW_W-1:0]  ge_d;
	logic [ROW_W-1:0]   sr_d;
	res_t               pair_r;
	res_t               end_r;
	logic               pair_v;

	assign proc     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			luma_s1  <= in_luma;
			green_s1 <= in_green;
			row_s1   <= in_row;
			first_s1 <= in_first;
			last_s1  <= in_last;
			id_s1    <= in_id;
		end
	end

	// gradient peak tracking and segment bookkeeping for one item
	always_comb begin
		logic signed [10:0] t;
		logic signed [10:0] neg_t;
		logic signed [10:0] g;
		logic [7:0]         prev;
		logic [12:0]        here_w;
		logic [PROW_W-1:0]  here;
		t      = $signed({2'b0, thr_q, 1'b0});
		neg_t  = -t;
		here_w = 13'(row_s1) + 13'd1;
		here   = (here_w > MAX_ROWS_W) ? MAX_ROWS_W[PROW_W-1:0] : here_w[PROW_W-1:0];
		prev   = prev_luma_q;
		gmax_d = grad_max_q;
		gmin_d = grad_min_q;
		peak_d = peak_row_q;
		bs_d   = begin_seen_q;
		pend_d = pend_row_q;
		gc_d   = green_cnt_q;
		sl_d   = seg_len_q;
		ge_d   = green_end_q;
		sr_d   = start_row_q;
		pair_v = 1'b0;
		pair_r = '0;
		end_r  = '0;

		// line start
		if (first_s1) begin
			prev   = luma_s1;
			gmin_d = t;
			gmax_d = neg_t;
			peak_d = '0;
			bs_d   = 1'b0;
			pend_d = '0;
			gc_d   = '0;
			sl_d   = '0;
			sr_d   = row_s1;
			ge_d   = PROW_W'(row_s1);
		end

		// saturating segment counters
		if (green_s1 && gc_d < COUNT_CAP) begin
			gc_d = gc_d + CNT_W'(1);
		end
		if (sl_d < COUNT_CAP) begin
			sl_d = sl_d + CNT_W'(1);
		end

		g = $signed({3'b0, luma_s1}) - $signed({3'b0, prev});

		// rising step: confirms a pending falling peak
		if (g > gmax_d) begin
			if (gmin_d < neg_t) begin
				if (green_enough(gc_d, sl_d)) begin
					ge_d = peak_d;
				end
				gc_d = '0;
				sl_d = CNT_W'(1);
				if (bs_d) begin
					bs_d             = 1'b0;
					pair_v           = 1'b1;
					pair_r.kind      = KIND_PAIR;
					pair_r.begin_row = pend_d;
					pair_r.end_row   = peak_d;
					pair_r.line_id   = id_s1;
					pair_r.last      = !last_s1;
				end
			end
			gmax_d = g;
			gmin_d = t;
			peak_d = here;
		end

		// falling step: confirms a pending rising peak
		if (g < gmin_d) begin
			if (gmax_d > t) begin
				if (green_enough(gc_d, sl_d)) begin
					ge_d = peak_d;
				end
				gc_d   = '0;
				sl_d   = CNT_W'(1);
				bs_d   = 1'b1;
				pend_d = peak_d;
			end
			gmax_d = neg_t;
			gmin_d = g;
			peak_d = here;
		end

		// line endpoint after the last pixel
		if (last_s1 && green_enough(gc_d, sl_d)) begin
			ge_d = peak_d;
		end
		end_r.kind      = KIND_END;
		end_r.begin_row = ge_d;
		end_r.at_start  = ge_d >= PROW_W'(sr_d);
		end_r.line_id   = id_s1;
		end_r.last      = 1'b1;
	end

	// results in order: pair first, then endpoint
	always_comb begin
		push.v0 = proc && (pair_v || last_s1);
		push.v1 = proc && pair_v && last_s1;
		push.r0 = pair_v ? pair_r : end_r;
		push.r1 = end_r;
	end

	// line state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_luma_q  <= '0;
			grad_max_q   <= '0;
			grad_min_q   <= '0;
			peak_row_q   <= '0;
			begin_seen_q <= 1'b0;
			pend_row_q   <= '0;
			green_cnt_q  <= '0;
			seg_len_q    <= '0;
			green_end_q  <= '0;
			start_row_q  <= '0;
		end else if (proc) begin
			prev_luma_q  <= luma_s1;
			grad_max_q   <= gmax_d;
			grad_min_q   <= gmin_d;
			peak_row_q   <= peak_d;
			begin_seen_q <= bs_d;
			pend_row_q   <= pend_d;
			green_cnt_q  <= gc_d;
			seg_len_q    <= sl_d;
			green_end_q  <= ge_d;
			start_row_q  <= sr_d;
		end
	end

	// a second result is always the endpoint of a last pixel
	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (last_s1 && push.r1.kind == KIND_END && push.r0.kind == KIND_PAIR))
		else $error("second result without line end");

	// an edge pair never claims the start flag
	a_pair_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(push.v0 && push.r0.kind == KIND_PAIR) |-> !push.r0.at_start)
		else $error("edge pair with start flag");

endmodule

`default_nettype wire

### rtl/scanline_edge_pair_detector.sv
// scanline_edge_pair_detector: top level, stream ports around core and result queue
// depends on sepd_pkg, sepd_core and sepd_fifo
//
// Usage:
//  - s_* channel: one pixel of a vertical scan line per item. s_tuser[1] marks
//    the first pixel of a line (state is re-initialized), s_tlast the last one.
//  - m_* channel: results. m_tuser[0] = 0 for an edge pair (begin/end rows),
//    1 for the line endpoint; m_tlast marks the final result of a pixel.
//  - cfg_we/cfg_data write the brightness step threshold; write only when idle.
//  - A pixel is first held in the input register; its results are then written
//    into the queue and offered on m_* from there.
//  - Throughput: one pixel per cycle while the queue has room; the gradient and
//    segment update is a single pass through the core between input register and queue.
//    A pixel with two results takes two queue entries; the four-entry
//    queue absorbs them and only stalls input when it holds more than two.
//  - Reset clears the line state, the queue and sets the threshold to 8.
//  - When m_tready is low, results wait in the queue and s_tready falls once
//    the queue cannot take two more results with a pixel held; nothing is dropped.
`default_nettype none

module scanline_edge_pair_detector
	import sepd_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // luma[7:0], row[17:8], line_id[23:18]
	input  wire logic [1:0]  s_tuser,   // is_field_color[0], first_of_line[1]
	input  wire logic        s_tlast,   // last_of_line
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // begin_row[10:0], end_row[21:11],
	                                    // out_line_id[27:22], zero[31:28]
	output logic [1:0]       m_tuser,   // kind[0], at_start[1]
	output logic             m_tlast    // last_result
);

	push_t push;
	logic  room;
	res_t  out_res;

	sepd_core #(
		.MAX_ROWS(MAX_ROWS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_luma  (s_tdata[7:0]),
		.in_green (s_tuser[0]),
		.in_row   (s_tdata[17:8]),
		.in_first (s_tuser[1]),
		.in_last  (s_tlast),
		.in_id    (s_tdata[23:18]),
		.room     (room),
		.push     (push)
	);

	sepd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// pack result item onto the output bus
	assign m_tdata = {4'b0, out_res.line_id, out_res.end_row, out_res.begin_row};
	assign m_tuser = {out_res.at_start, out_res.kind};
	assign m_tlast = out_res.last;

endmodule

`default_nettype wire

### dv/sepd_checker.sv
// sepd_checker: watches the pixel, result and threshold ports of the scan line edge pair
// detector, predicts every result item and compares it field by field
// depends on sepd_pkg for the result kind codes and the row limit
`timescale 1ns / 1ps

module sepd_checker
	import sepd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [7:0]  cfg_data,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [23:0] s_tdata,   // luma[7:0], row[17:8], line_id[23:18]
	input  wire logic [1:0]  s_tuser,   // is_field_color[0], first_of_line[1]
	input  wire logic        s_tlast,   // last_of_line
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [31:0] m_tdata,   // begin_row[10:0], end_row[21:11], out_line_id[27:22]
	input  wire logic [1:0]  m_tuser,   // kind[0], at_start[1]
	input  wire logic        m_tlast,   // last_result
	output int               fail_count,
	output int               outstanding
);

	typedef struct packed {
		logic        kind;
		logic [10:0] begin_row;
		logic [10:0] end_row;
		logic        at_start;
		logic [5:0]  line_id;
		logic        last;
	} scan_result_t;

	// results predicted but not yet seen on the master side, oldest first
	scan_result_t awaited_results[$];
	scan_result_t want;

	// predictor copy of the threshold register and the line state
	logic [7:0]         threshold = THR_RESET;
	logic [7:0]         prev_luma = '0;
	logic signed [10:0] grad_max = '0;
	logic signed [10:0] grad_min = '0;
	logic [10:0]        peak_row = '0;
	logic               begin_seen = 1'b0;
	logic [10:0]        pending_begin_row = '0;
	logic [10:0]        green_count = '0;
	logic [10:0]        segment_length = '0;
	logic [10:0]        green_end_row = '0;
	logic [9:0]         start_row = '0;

	initial begin
		fail_count = 0;
		outstanding = 0;
	end

	// green share above 0.3
	function automatic bit mostly_green(input logic [10:0] gc, input logic [10:0] sl);
		return int'(gc) * 10 > int'(sl) * 3;
	endfunction

	// a peak closes the segment; a green enough one moves the endpoint
	task automatic close_run();
		if (mostly_green(green_count, segment_length))
			green_end_row = peak_row;
		green_count = '0;
		segment_length = 11'd1;
	endtask

	task automatic predict_pixel(input logic [7:0] luma, input logic green,
			input logic [9:0] row, input logic first, input logic last,
			input logic [5:0] id);
		logic signed [10:0] t;
		logic signed [10:0] g;
		logic [10:0]        here;
		scan_result_t       hits[2];
		int                 n;
		n = 0;
		t = $signed({2'b00, threshold, 1'b0});
		here = {1'b0, row} + 11'd1;
		if (here > MAX_ROWS_DEF)
			here = 11'(MAX_ROWS_DEF);

		// line start re-initializes everything before the pixel is used
		if (first) begin
			prev_luma = luma;
			grad_min = t;
			grad_max = -t;
			peak_row = '0;
			begin_seen = 1'b0;
			pending_begin_row = '0;
			green_count = '0;
			segment_length = '0;
			start_row = row;
			green_end_row = {1'b0, row};
		end

		if (green && green_count < COUNT_CAP)
			green_count = green_count + 11'd1;
		if (segment_length < COUNT_CAP)
			segment_length = segment_length + 11'd1;

		g = $signed({3'b000, luma}) - $signed({3'b000, prev_luma});

		// rising difference: confirms a pending falling peak
		if (g > grad_max) begin
			if (grad_min < -t) begin
				close_run();
				if (begin_seen) begin
					begin_seen = 1'b0;
					hits[n] = '{kind: KIND_PAIR, begin_row: pending_begin_row,
						end_row: peak_row, at_start: 1'b0, line_id: id, last: 1'b0};
					n++;
				end
			end
			grad_max = g;
			grad_min = t;
			peak_row = here;
		end

		// falling difference: confirms a pending rising peak
		if (g < grad_min) begin
			if (grad_max > t) begin
				close_run();
				begin_seen = 1'b1;
				pending_begin_row = peak_row;
			end
			grad_max = -t;
			grad_min = g;
			peak_row = here;
		end

		prev_luma = luma;

		// endpoint of the line after its last pixel
		if (last) begin
			if (mostly_green(green_count, segment_length))
				green_end_row = peak_row;
			hits[n] = '{kind: KIND_END, begin_row: green_end_row, end_row: 11'd0,
				at_start: green_end_row >= {1'b0, start_row}, line_id: id, last: 1'b0};
			n++;
		end

		if (n > 0)
			hits[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			awaited_results = {awaited_results, hits[i]};
	endtask

	task automatic check_field(input string name, input logic [10:0] exp_val,
			input logic [10:0] act_val);
		if (act_val !== exp_val) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
				exp_val, act_val);
		end
	endtask

	// predict on every accepted pixel, compare on every accepted result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold = THR_RESET;
			prev_luma = '0;
			grad_max = '0;
			grad_min = '0;
			peak_row = '0;
			begin_seen = 1'b0;
			pending_begin_row = '0;
			green_count = '0;
			segment_length = '0;
			green_end_row = '0;
			start_row = '0;
			awaited_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				threshold = cfg_data;
			if (s_tvalid && s_tready)
				predict_pixel(s_tdata[7:0], s_tuser[0], s_tdata[17:8], s_tuser[1],
					s_tlast, s_tdata[23:18]);
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					fail_count++;
					$display("%0t: result with none expected, expected nothing, actual %h %h %b",
						$time, m_tdata, m_tuser, m_tlast);
				end else begin
					want = awaited_results.pop_front();
					check_field("kind", 11'(want.kind), 11'(m_tuser[0]));
					check_field("begin_row", want.begin_row, m_tdata[10:0]);
					check_field("end_row", want.end_row, m_tdata[21:11]);
					check_field("at_start", 11'(want.at_start), 11'(m_tuser[1]));
					check_field("line_id", 11'(want.line_id), 11'(m_tdata[27:22]));
					check_field("last_result", 11'(want.last), 11'(m_tlast));
				end
			end
			outstanding = awaited_results.size();
		end
	end

endmodule

### dv/scanline_edge_pair_detector_test.sv
// scanline_edge_pair_detector_test: drives pixels, thresholds and result back-pressure
// into the edge pair detector and gives the verdict from the checker's failure count
// depends on sepd_pkg, scanline_edge_pair_detector and sepd_checker
`timescale 1ns / 1ps

module scanline_edge_pair_detector_test;

	localparam int RUN_LIMIT = 400000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int outstanding;
	int cycles = 0;
	int pixels_sent = 0;
	bit calm = 1'b0;

	scanline_edge_pair_detector uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sepd_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		while (cycles < RUN_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb: failure");
		$finish;
	end

	// result side back-pressure: ready bursts and stalls of random length
	initial begin : sink_pacing
		int  hold;
		bit  level;
		hold = 0;
		level = 1'b1;
		forever begin
			@(negedge clk);
			if (hold == 0) begin
				if (calm) begin
					level = 1'b1;
					hold = 1;
				end else begin
					level = $urandom_range(0, 99) < 65;
					if (level)
						hold = $urandom_range(1, 12);
					else if ($urandom_range(0, 99) < 90)
						hold = $urandom_range(1, 3);
					else
						hold = $urandom_range(10, 40);
				end
			end
			m_tready <= level;
			hold--;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// one pixel item; called and left at a falling edge
	task automatic send_pixel(input logic [7:0] luma, input logic green,
			input logic [9:0] row, input logic first, input logic last,
			input logic [5:0] id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata <= {id, row, luma};
		s_tuser <= {first, green};
		s_tlast <= last;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		pixels_sent++;
		@(negedge clk);
	endtask

	// threshold write once the pipe has drained
	task automatic write_threshold(input logic [7:0] value);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_data <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one scan line of random content: mostly well formed, some noise
	task automatic random_line();
		int         shape;
		int         len;
		int         bias;
		int         cut;
		logic [7:0] luma;
		logic [9:0] row;
		logic [5:0] id;
		logic       first;
		logic       last;
		shape = $urandom_range(0, 99);
		cut = -1;
		if ($urandom_range(0, 99) < 75)
			len = $urandom_range(1, 12);
		else if ($urandom_range(0, 99) < 80)
			len = $urandom_range(13, 40);
		else
			len = $urandom_range(41, 120);
		if (shape >= 80 && shape < 90)
			len = $urandom_range(1, 5);
		if (shape >= 90)
			cut = $urandom_range(0, len);
		row = 10'($urandom_range(0, 1023));
		id = 6'($urandom_range(0, 63));
		luma = 8'($urandom_range(0, 255));
		bias = $urandom_range(0, 100);
		for (int i = 0; i < len; i++) begin
			// brightness steps make the peaks, small jitter between them
			if ($urandom_range(0, 99) < 30) begin
				luma = 8'($urandom_range(0, 255));
				bias = $urandom_range(0, 100);
			end else begin
				luma = 8'(int'(luma) + $urandom_range(0, 6) - 3);
			end
			if (shape < 80) begin
				first = (i == 0);
				last = (i == len - 1);
			end else if (shape < 90) begin
				first = $urandom_range(0, 99) < 5;
				last = $urandom_range(0, 99) < 5;
			end else begin
				// broken line: a restart part way, or no last pixel
				first = (i == 0) || (i == cut);
				last = (i == len - 1) && (cut == len);
			end
			send_pixel(luma, $urandom_range(0, 99) < bias, row, first, last, id);
			row = row - 10'(($urandom_range(0, 99) < 85) ? 1 : $urandom_range(2, 5));
		end
	endtask

	initial begin : stimulus
		int         r;
		int         lines;
		logic [7:0] value;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray pixel right after reset, state still cleared
		send_pixel(8'd255, 1'b1, 10'd1023, 1'b0, 1'b0, 6'd63);
		// rise then fall, pair and endpoint from the same last pixel
		send_pixel(8'd0, 1'b1, 10'd1023, 1'b1, 1'b0, 6'd0);
		send_pixel(8'd0, 1'b1, 10'd1022, 1'b0, 1'b0, 6'd0);
		send_pixel(8'd200, 1'b0, 10'd1021, 1'b0, 1'b0, 6'd0);
		send_pixel(8'd200, 1'b0, 10'd1020, 1'b0, 1'b0, 6'd0);
		send_pixel(8'd0, 1'b1, 10'd1019, 1'b0, 1'b0, 6'd0);
		send_pixel(8'd0, 1'b1, 10'd1018, 1'b0, 1'b1, 6'd0);
		// single pixel lines, at both ends of the row range
		send_pixel(8'd128, 1'b1, 10'd0, 1'b1, 1'b1, 6'd1);
		send_pixel(8'd0, 1'b0, 10'd1023, 1'b1, 1'b1, 6'd2);
		// full swing luminance
		send_pixel(8'd0, 1'b0, 10'd500, 1'b1, 1'b0, 6'd42);
		send_pixel(8'd255, 1'b1, 10'd499, 1'b0, 1'b0, 6'd42);
		send_pixel(8'd255, 1'b1, 10'd498, 1'b0, 1'b0, 6'd42);
		send_pixel(8'd0, 1'b0, 10'd497, 1'b0, 1'b0, 6'd42);
		send_pixel(8'd0, 1'b0, 10'd496, 1'b0, 1'b0, 6'd42);
		send_pixel(8'd255, 1'b1, 10'd495, 1'b0, 1'b1, 6'd42);
		// pixels with no line start carry on with the old state
		send_pixel(8'd10, 1'b0, 10'd300, 1'b0, 1'b0, 6'd3);
		send_pixel(8'd40, 1'b1, 10'd299, 1'b0, 1'b1, 6'd3);
		// a line restarted before its end
		send_pixel(8'd50, 1'b0, 10'd200, 1'b1, 1'b0, 6'd4);
		send_pixel(8'd90, 1'b1, 10'd199, 1'b0, 1'b0, 6'd4);
		send_pixel(8'd20, 1'b0, 10'd600, 1'b1, 1'b0, 6'd5);
		send_pixel(8'd20, 1'b1, 10'd599, 1'b0, 1'b1, 6'd5);

		// zero threshold: every change is a peak
		write_threshold(8'd0);
		send_pixel(8'd0, 1'b0, 10'd10, 1'b1, 1'b0, 6'd9);
		send_pixel(8'd1, 1'b1, 10'd9, 1'b0, 1'b0, 6'd9);
		send_pixel(8'd1, 1'b1, 10'd8, 1'b0, 1'b0, 6'd9);
		send_pixel(8'd0, 1'b0, 10'd7, 1'b0, 1'b0, 6'd9);
		send_pixel(8'd0, 1'b0, 10'd6, 1'b0, 1'b0, 6'd9);
		send_pixel(8'd1, 1'b1, 10'd5, 1'b0, 1'b1, 6'd9);

		// largest threshold: no peak can pass
		write_threshold(8'd255);
		send_pixel(8'd0, 1'b1, 10'd100, 1'b1, 1'b0, 6'd10);
		send_pixel(8'd255, 1'b1, 10'd99, 1'b0, 1'b0, 6'd10);
		send_pixel(8'd0, 1'b0, 10'd98, 1'b0, 1'b1, 6'd10);

		// random lines in phases of one threshold each
		while (pixels_sent < 450) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				value = 8'd0;
			else if (r < 20)
				value = 8'd255;
			else if (r < 70)
				value = 8'($urandom_range(1, 20));
			else
				value = 8'($urandom_range(0, 255));
			write_threshold(value);
			calm = $urandom_range(0, 99) < 20;
			lines = $urandom_range(4, 8);
			repeat (lines) random_line();
			calm = 1'b0;
		end

		// drain and let the pipe settle
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
